>>> sv/takf_pkg.sv
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter package
// Word types, register indexes, sequencer states and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package takf_pkg;

   // Input word: accelerometer angle and gyro rate, signed Q16.16.
   typedef struct packed {
      logic signed [31:0] measured_angle;
      logic signed [31:0] gyro_rate;
   } req_word_type;

   // Result word: filtered angle and bias-corrected rate, signed Q16.16.
   typedef struct packed {
      logic signed [31:0] filtered_angle;
      logic signed [31:0] filtered_rate;
   } rsp_word_type;

   // Configuration register indexes.
   localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
   localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
   localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;
   localparam logic [1:0] REG_STEP_TIME   = 2'd3;

   // Reset values of the configuration registers, unsigned Q1.30.
   localparam logic [30:0] ANGLE_NOISE_RESET = 31'd3221225;
   localparam logic [30:0] BIAS_NOISE_RESET  = 31'd1073742;
   localparam logic [30:0] MEAS_NOISE_RESET  = 31'd10737418;
   localparam logic [30:0] STEP_TIME_RESET   = 31'd10737418;

   localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

   // Multiply steps run by the shared multiplier, in order.
   localparam logic [3:0] STEP_RATE_DT  = 4'd0;
   localparam logic [3:0] STEP_QA_DT    = 4'd1;
   localparam logic [3:0] STEP_P01_DT   = 4'd2;
   localparam logic [3:0] STEP_P10_DT   = 4'd3;
   localparam logic [3:0] STEP_P11_DT   = 4'd4;
   localparam logic [3:0] STEP_QB_DT    = 4'd5;
   localparam logic [3:0] STEP_K1_P01   = 4'd6;
   localparam logic [3:0] STEP_K0_P01   = 4'd7;
   localparam logic [3:0] STEP_K1_P00   = 4'd8;
   localparam logic [3:0] STEP_K0_P00   = 4'd9;
   localparam logic [3:0] STEP_K0_INNOV = 4'd10;
   localparam logic [3:0] STEP_K1_INNOV = 4'd11;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RATE,
      ST_MUL,
      ST_ACC,
      ST_DIV_LOAD,
      ST_DIV_ITER,
      ST_DIV_DONE,
      ST_DONE
   } state_type;

   // Saturate a 40-bit signed value to signed 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
      logic signed [31:0] r;
      if (x > 40'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> sv/tilt_angle_kalman_filter.sv
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter
// Two-state filter (angle, gyro bias) with a shared multiplier and a
// bit-serial divider run by a small sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | word
//  req     | in        | req_valid / req_ready | req_word_type
//  rsp     | out       | rsp_valid / rsp_ready | rsp_word_type
//  csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// Each word runs 12 multiply steps through the one 32x32 multiplier and, unless
// the divisor is zero, two gain divisions in the restoring divider, which
// retires one quotient bit per cycle.
// Reset is synchronous and restores the registers, estimates and covariance.
// A finished result waits in the output register; a new word is taken as soon
// as the sequencer is idle, and the sequencer holds before writing a result
// while the previous one is still not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_angle_kalman_filter (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire takf_pkg::req_word_type req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output takf_pkg::rsp_word_type   rsp_data,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire  [1:0]               csr_index,
   input  wire  [31:0]              csr_data
);
   import takf_pkg::*;

   // Configuration registers.
   logic [30:0] qa_ff, qb_ff, r_ff, dt_ff;

   // Filter state and working registers.
   logic signed [31:0] ang_ff, bias_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [31:0] meas_ff, gyro_ff, rate_ff, innov_ff, k0_ff, k1_ff;
   logic signed [39:0] acc_ff;
   logic signed [63:0] prod_ff;
   logic [3:0]         step_ff;
   logic               gsel_ff;

   // Divider registers.
   logic [61:0] num_ff, quo_ff;
   logic [31:0] den_ff;
   logic [33:0] rem_ff;
   logic        neg_ff;
   logic [5:0]  cnt_ff;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   rsp_word_type rsp_data_ff;

   // Multiplier operand selection by step.
   logic signed [31:0] op_a, op_b;
   always_comb begin
      op_a = rate_ff;
      op_b = $signed({1'b0, dt_ff});
      case (step_ff)
         STEP_RATE_DT:  begin op_a = rate_ff;                op_b = $signed({1'b0, dt_ff}); end
         STEP_QA_DT:    begin op_a = $signed({1'b0, qa_ff}); op_b = $signed({1'b0, dt_ff}); end
         STEP_P01_DT:   begin op_a = p01_ff;                 op_b = $signed({1'b0, dt_ff}); end
         STEP_P10_DT:   begin op_a = p10_ff;                 op_b = $signed({1'b0, dt_ff}); end
         STEP_P11_DT:   begin op_a = p11_ff;                 op_b = $signed({1'b0, dt_ff}); end
         STEP_QB_DT:    begin op_a = $signed({1'b0, qb_ff}); op_b = $signed({1'b0, dt_ff}); end
         STEP_K1_P01:   begin op_a = k1_ff;                  op_b = p01_ff;                 end
         STEP_K0_P01:   begin op_a = k0_ff;                  op_b = p01_ff;                 end
         STEP_K1_P00:   begin op_a = k1_ff;                  op_b = p00_ff;                 end
         STEP_K0_P00:   begin op_a = k0_ff;                  op_b = p00_ff;                 end
         STEP_K0_INNOV: begin op_a = k0_ff;                  op_b = innov_ff;               end
         STEP_K1_INNOV: begin op_a = k1_ff;                  op_b = innov_ff;               end
         default:       begin op_a = rate_ff;                op_b = $signed({1'b0, dt_ff}); end
      endcase
   end

   // Rounded Q30 product: add half, take the floor of the shift.
   logic signed [63:0] prod_rnd;
   logic signed [33:0] mval;
   logic signed [39:0] mval_x;
   assign prod_rnd = prod_ff + 64'sd536870912;
   assign mval     = prod_rnd[63:30];
   assign mval_x   = {{6{mval[33]}}, mval};

   // Divider setup values.
   logic signed [31:0] div_p;
   logic signed [32:0] e_sum;
   logic [31:0]        p_mag, e_mag;
   assign div_p = gsel_ff ? p10_ff : p00_ff;
   assign e_sum = {p00_ff[31], p00_ff} + $signed({2'b00, r_ff});
   assign p_mag = div_p[31] ? 32'(-{div_p[31], div_p}) : div_p;
   assign e_mag = e_sum[32] ? 32'(-e_sum) : e_sum[31:0];

   // One restoring division step.
   logic [33:0] rem_sh;
   logic        qbit;
   assign rem_sh = {rem_ff[32:0], num_ff[61]};
   assign qbit   = rem_sh >= {2'b00, den_ff};

   // Signed, saturated gain from the quotient magnitude.
   logic signed [31:0] gain;
   always_comb begin
      if (neg_ff) begin
         gain = (quo_ff > 62'd2147483648) ? 32'sh80000000 : 32'(-quo_ff);
      end else begin
         gain = (quo_ff > 62'd2147483647) ? 32'sh7fffffff : quo_ff[31:0];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_RATE;
         ST_RATE:     state_in = ST_MUL;
         ST_MUL:      state_in = ST_ACC;
         ST_ACC: begin
            if (step_ff == STEP_QB_DT)         state_in = ST_DIV_LOAD;
            else if (step_ff == STEP_K1_INNOV) state_in = ST_DONE;
            else                               state_in = ST_MUL;
         end
         ST_DIV_LOAD: state_in = (e_sum == 33'sd0) ? ST_MUL : ST_DIV_ITER;
         ST_DIV_ITER: if (cnt_ff == 6'd0) state_in = ST_DIV_DONE;
         ST_DIV_DONE: state_in = gsel_ff ? ST_MUL : ST_DIV_LOAD;
         ST_DONE:     if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      csr_ready = 1'b1;
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         qa_ff <= ANGLE_NOISE_RESET;
         qb_ff <= BIAS_NOISE_RESET;
         r_ff  <= MEAS_NOISE_RESET;
         dt_ff <= STEP_TIME_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ANGLE_NOISE: qa_ff <= csr_data[30:0];
            REG_BIAS_NOISE:  qb_ff <= csr_data[30:0];
            REG_MEAS_NOISE:  r_ff  <= csr_data[30:0];
            REG_STEP_TIME:   dt_ff <= csr_data[30:0];
            default:         ;
         endcase
      end
   end

   // Filter state and datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         ang_ff  <= '0;
         bias_ff <= '0;
         p00_ff  <= ONE_Q30;
         p01_ff  <= '0;
         p10_ff  <= '0;
         p11_ff  <= ONE_Q30;
         step_ff <= STEP_RATE_DT;
         gsel_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  meas_ff <= req_data.measured_angle;
                  gyro_ff <= req_data.gyro_rate;
               end
               step_ff <= STEP_RATE_DT;
               gsel_ff <= 1'b0;
            end
            ST_RATE: begin
               rate_ff <= sat32(40'(gyro_ff) - 40'(bias_ff));
            end
            ST_MUL: begin
               prod_ff <= op_a * op_b;
            end
            ST_ACC: begin
               step_ff <= step_ff + 4'd1;
               case (step_ff)
                  STEP_RATE_DT:  ang_ff <= sat32(40'(ang_ff) + mval_x);
                  STEP_QA_DT:    acc_ff <= 40'(p00_ff) + mval_x;
                  STEP_P01_DT:   acc_ff <= acc_ff - mval_x;
                  STEP_P10_DT:   p00_ff <= sat32(acc_ff - mval_x);
                  STEP_P11_DT: begin
                     p01_ff <= sat32(40'(p01_ff) - mval_x);
                     p10_ff <= sat32(40'(p10_ff) - mval_x);
                  end
                  STEP_QB_DT: begin
                     p11_ff   <= sat32(40'(p11_ff) + mval_x);
                     innov_ff <= sat32(40'(meas_ff) - 40'(ang_ff));
                  end
                  STEP_K1_P01:   p11_ff  <= sat32(40'(p11_ff) - mval_x);
                  STEP_K0_P01:   p01_ff  <= sat32(40'(p01_ff) - mval_x);
                  STEP_K1_P00:   p10_ff  <= sat32(40'(p10_ff) - mval_x);
                  STEP_K0_P00:   p00_ff  <= sat32(40'(p00_ff) - mval_x);
                  STEP_K0_INNOV: ang_ff  <= sat32(40'(ang_ff) + mval_x);
                  STEP_K1_INNOV: bias_ff <= sat32(40'(bias_ff) + mval_x);
                  default:       ;
               endcase
            end
            ST_DIV_LOAD: begin
               num_ff <= {p_mag, 30'd0};
               den_ff <= e_mag;
               neg_ff <= div_p[31] ^ e_sum[32];
               rem_ff <= '0;
               quo_ff <= '0;
               cnt_ff <= 6'd61;
               // A zero divisor gives zero for both gains.
               if (e_sum == 33'sd0) begin
                  k0_ff <= '0;
                  k1_ff <= '0;
               end
            end
            ST_DIV_ITER: begin
               rem_ff <= qbit ? rem_sh - {2'b00, den_ff} : rem_sh;
               num_ff <= {num_ff[60:0], 1'b0};
               quo_ff <= {quo_ff[60:0], qbit};
               cnt_ff <= cnt_ff - 6'd1;
            end
            ST_DIV_DONE: begin
               if (gsel_ff) begin
                  k1_ff <= gain;
               end else begin
                  k0_ff <= gain;
               end
               gsel_ff <= 1'b1;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff.filtered_angle <= ang_ff;
                  rsp_data_ff.filtered_rate  <= sat32(40'(gyro_ff) - 40'(bias_ff));
               end
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> sv/takf_checker.sv
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module takf_checker (
   input wire                     clock,
   input wire                     reset,
   input wire                     req_valid,
   input wire                     req_ready,
   input wire                     rsp_valid,
   input wire                     rsp_ready,
   input wire takf_pkg::rsp_word_type rsp_data
);

   // A result word that is not taken holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word dropped or changed while stalled");

   // After a word is taken the block is busy.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again while busy");

   // A result never appears the cycle after an input word is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind tilt_angle_kalman_filter takf_checker u_takf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter testbench
// Drives accelerometer and gyro words through the filter under several
// register settings and idle patterns. Each accepted word is run through a
// bit-exact predictor of the filter, and every result word is checked
// against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import takf_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 400;
   localparam int LONG_HOLD = 3000;
   localparam int WORDS_PER_PHASE = 125;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   // Words waiting to be offered and results waiting to be seen.
   req_word_type pending_words[$];
   rsp_word_type expected_results[$];

   int words_offered = 0;
   int words_accepted = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit long_hold = 1'b0;
   int hold_count = 0;

   // Predictor state: registers, estimates and covariance.
   longint qa, qb, meas_noise, dt;
   longint angle_est, bias_est;
   longint p00, p01, p10, p11;

   tilt_angle_kalman_filter DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint clamp32(longint x);
      if (x > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (x < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return x;
   endfunction

   // Q30 product, rounded half up.
   function automatic longint mul_q30(longint a, longint b);
      return (a * b + 64'sd536870912) >>> 30;
   endfunction

   function automatic void reset_filter_model();
      qa = ANGLE_NOISE_RESET;
      qb = BIAS_NOISE_RESET;
      meas_noise = MEAS_NOISE_RESET;
      dt = STEP_TIME_RESET;
      angle_est = 0;
      bias_est = 0;
      p00 = 64'sd1073741824;
      p01 = 0;
      p10 = 0;
      p11 = 64'sd1073741824;
   endfunction

   // One filter step: predict, gain, update; returns the result word.
   function automatic rsp_word_type kalman_step(req_word_type w);
      longint meas, gyro, rate, innov, e, k0, k1, n00, n01, n10, n11;
      rsp_word_type r;
      meas = longint'(w.measured_angle);
      gyro = longint'(w.gyro_rate);
      rate = clamp32(gyro - bias_est);
      angle_est = clamp32(angle_est + mul_q30(rate, dt));
      n00 = clamp32(p00 + mul_q30(qa, dt) - mul_q30(p01, dt) - mul_q30(p10, dt));
      n01 = clamp32(p01 - mul_q30(p11, dt));
      n10 = clamp32(p10 - mul_q30(p11, dt));
      n11 = clamp32(p11 + mul_q30(qb, dt));
      innov = clamp32(meas - angle_est);
      e = n00 + meas_noise;
      if (e == 0) begin
         k0 = 0;
         k1 = 0;
      end else begin
         k0 = clamp32((n00 * 64'sd1073741824) / e);
         k1 = clamp32((n10 * 64'sd1073741824) / e);
      end
      p00 = clamp32(n00 - mul_q30(k0, n00));
      p01 = clamp32(n01 - mul_q30(k0, n01));
      p10 = clamp32(n10 - mul_q30(k1, n00));
      p11 = clamp32(n11 - mul_q30(k1, n01));
      angle_est = clamp32(angle_est + mul_q30(k0, innov));
      bias_est = clamp32(bias_est + mul_q30(k1, innov));
      r.filtered_angle = angle_est[31:0];
      r.filtered_rate = 32'(clamp32(gyro - bias_est));
      return r;
   endfunction

   // Driver: offer queued words, holding each until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && words_offered != words_accepted) begin
         req_valid <= 1'b1;
      end else if (pending_words.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
         req_data <= pending_words.pop_front();
         req_valid <= 1'b1;
         words_offered <= words_offered + 1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: random stalls plus one long hold-off.
   always @(negedge clock) begin
      if (long_hold && hold_count < LONG_HOLD) begin
         hold_count <= hold_count + 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: predict on each accepted word, check each result word.
   always @(posedge clock) begin
      rsp_word_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
      if (!reset && req_valid && req_ready) begin
         expected_results.push_back(kalman_step(req_data));
         words_accepted <= words_accepted + 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result word %h", rsp_data);
            mismatches = mismatches + 1;
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.filtered_angle !== want.filtered_angle) begin
               $error("filtered_angle: expected %h, actual %h",
                      want.filtered_angle, rsp_data.filtered_angle);
               mismatches = mismatches + 1;
            end
            if (rsp_data.filtered_rate !== want.filtered_rate) begin
               $error("filtered_rate: expected %h, actual %h",
                      want.filtered_rate, rsp_data.filtered_rate);
               mismatches = mismatches + 1;
            end
         end
      end
   end

   // Register write; the predictor copy keeps the low 31 bits.
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_ANGLE_NOISE: qa = longint'(value[30:0]);
         REG_BIAS_NOISE:  qb = longint'(value[30:0]);
         REG_MEAS_NOISE:  meas_noise = longint'(value[30:0]);
         REG_STEP_TIME:   dt = longint'(value[30:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every queued word is taken and every result has arrived.
   task automatic drain();
      while (pending_words.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
   endtask

   task automatic push_word(input logic [31:0] ang, input logic [31:0] gyr);
      req_word_type w;
      w.measured_angle = ang;
      w.gyro_rate = gyr;
      pending_words.push_back(w);
   endtask

   // Mostly plausible tilt angles and rates, sometimes any 32-bit value.
   function automatic logic [31:0] random_field(input int span);
      if ($urandom_range(3) == 0) begin
         return $urandom;
      end
      return 32'(int'($urandom_range(2 * span)) - span) <<< 16;
   endfunction

   initial begin
      logic [31:0] extremes[6];
      reset_filter_model();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed words: field extremes at the reset settings.
      extremes = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff,
                   32'h00010000, 32'hffff0000};
      foreach (extremes[i]) push_word(extremes[i], extremes[(i + 1) % 6]);
      foreach (extremes[i]) push_word(extremes[5 - i], extremes[i]);
      push_word(32'h0, 32'h0);
      push_word(32'h7fffffff, 32'h7fffffff);
      push_word(32'h80000000, 32'h80000000);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         // Registers change only while the filter is idle.
         repeat (DRAIN_CYCLES) @(posedge clock);
         case (phase)
            0: begin
               write_reg(REG_ANGLE_NOISE, 32'd3221225);
               write_reg(REG_BIAS_NOISE, 32'd1073742);
               write_reg(REG_MEAS_NOISE, 32'd10737418);
               write_reg(REG_STEP_TIME, 32'd10737418);
            end
            1: begin
               write_reg(REG_ANGLE_NOISE, $urandom_range(32'd50000000));
               write_reg(REG_BIAS_NOISE, $urandom_range(32'd50000000));
               write_reg(REG_MEAS_NOISE, $urandom_range(32'd200000000, 1));
               write_reg(REG_STEP_TIME, $urandom_range(32'd100000000, 1));
            end
            2: begin
               // Largest values, with the ignored top bit set on the angle and measurement noise.
               write_reg(REG_ANGLE_NOISE, 32'hffffffff);
               write_reg(REG_BIAS_NOISE, 32'h7fffffff);
               write_reg(REG_MEAS_NOISE, 32'hffffffff);
               write_reg(REG_STEP_TIME, 32'h7fffffff);
            end
            3: begin
               // Zero noises and step time; a zero divisor becomes possible.
               write_reg(REG_ANGLE_NOISE, 32'h0);
               write_reg(REG_BIAS_NOISE, 32'h80000000);
               write_reg(REG_MEAS_NOISE, 32'h0);
               write_reg(REG_STEP_TIME, 32'h0);
            end
            4: begin
               write_reg(REG_ANGLE_NOISE, 32'd1);
               write_reg(REG_BIAS_NOISE, 32'd1);
               write_reg(REG_MEAS_NOISE, 32'd1);
               write_reg(REG_STEP_TIME, 32'd1);
            end
            default: begin
               write_reg(REG_ANGLE_NOISE, $urandom);
               write_reg(REG_BIAS_NOISE, $urandom);
               write_reg(REG_MEAS_NOISE, $urandom);
               write_reg(REG_STEP_TIME, $urandom);
            end
         endcase

         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         // Long receiver hold-off while the sender keeps offering words.
         if (phase == 1) long_hold = 1'b1;

         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            push_word(random_field(180), random_field(500));
            // Sender pause until every result is in.
            if (phase == 2 && n == WORDS_PER_PHASE / 2) drain();
         end
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
